// ----- src/fas_pkg.sv -----
// Package: shared widths and payload types for the float add/subtract block.
package fas_pkg;
  localparam int unsigned WordW = 32;
  localparam int unsigned SumW  = 26;
  localparam logic ActAdd = 1'b0;
  localparam logic ActSub = 1'b1;

  typedef struct packed {
    logic             action;
    logic [WordW-1:0] operand_a;
    logic [WordW-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] sum_bits;
  } out_item_t;
endpackage

// ----- src/fas_in_if.sv -----
// Interface: input channel carrying action and two operands.
interface fas_in_if;
  logic               valid;
  logic               ready;
  fas_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/fas_out_if.sv -----
// Interface: result channel carrying the sum bit pattern.
interface fas_out_if;
  logic               valid;
  logic               ready;
  fas_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/float_add_sub.sv -----
// Top level: single-precision float add/subtract with truncation.
// Stages: input reg, then result reg.
// Throughput: one item per cycle; the two register stages advance together
//   whenever the result stage is empty or being taken.
// Reset: rst_n synchronous active low clears both stage valid flags only.
module float_add_sub (
  input  logic      clk,
  input  logic      rst_n,
  fas_in_if.sink    in_ch,
  fas_out_if.source out_ch
);
  // Stage 1: input register
  logic                 s1_vld_r;
  fas_pkg::in_item_t    s1_r;
  // Stage 2: result register
  logic                 s2_vld_r;
  logic [31:0]          s2_r;
  logic                 adv;

  // Whole pipe moves when the output is free; stalls hold both stages.
  assign adv          = !s2_vld_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign out_ch.valid = s2_vld_r;
  assign out_ch.data.sum_bits = s2_r;

  // Datapath from stage 1 registers
  logic [31:0] opa, opb, lg, sm;
  logic        a_large, same_sign;
  logic [7:0]  exp_lg, exp_sm, exp_diff;
  logic [24:0] sig_lg, sig_sm, aligned;
  logic [25:0] raw, norm;
  logic [4:0]  lead;
  logic        zero_sum;
  logic [9:0]  exp_n;
  logic        under, over;
  logic [7:0]  e;
  logic [22:0] f;
  logic [31:0] res_nxt;

  always_comb begin
    opa = s1_r.operand_a;
    opb = s1_r.operand_b;
    if (s1_r.action == fas_pkg::ActSub) begin
      opb[31] = ~opb[31];
    end
    a_large   = opa[30:0] > opb[30:0];
    lg        = a_large ? opa : opb;
    sm        = a_large ? opb : opa;
    same_sign = opa[31] == opb[31];
    exp_lg    = lg[30:23];
    exp_sm    = sm[30:23];
    sig_lg    = {1'b1, lg[22:0], 1'b0};
    sig_sm    = {1'b1, sm[22:0], 1'b0};
    // lg magnitude >= sm so exponent difference is never negative; max 255
    exp_diff  = exp_lg - exp_sm;
    aligned   = (exp_diff >= 8'd32) ? '0 : (sig_sm >> exp_diff);
    raw       = same_sign ? ({1'b0, sig_lg} + {1'b0, aligned})
                          : ({1'b0, sig_lg} - {1'b0, aligned});
    // leading-one search over the 26-bit sum
    lead     = 5'd0;
    zero_sum = 1'b1;
    for (int i = 0; i < 26; i++) begin
      if (zero_sum && raw[25-i]) begin
        lead     = 5'(i);
        zero_sum = 1'b0;
      end
    end
    norm  = raw << lead;
    exp_n = {2'b00, exp_lg} + 10'd1 - {5'd0, lead};
    under = exp_n[9] || exp_lg == 8'd0 || exp_n == 10'd0 || zero_sum;
    over  = exp_n[8] || exp_lg == 8'd255 || exp_n == 10'd255;
    priority if (exp_sm == 8'd0) begin
      e = exp_lg;
      f = lg[22:0];
    end else if (under) begin
      e = 8'd0;
      f = '0;
    end else if (over) begin
      e = 8'd255;
      f = '0;
    end else begin
      e = exp_n[7:0];
      f = norm[24:2];
    end
    res_nxt = {lg[31], e, f};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_ch.valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= in_ch.data;
      s2_r <= res_nxt;
    end
  end

`ifndef SYNTHESIS
  // a stalled result must hold its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed while stalled");
  // an accepted input shows up as valid in the input register stage
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_vld_r)
    else $error("input transfer lost");
  // an overflowed result never carries a nonzero fraction
  a_inf: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && adv && exp_sm != 8'd0 && !under && over |=> s2_r[22:0] == 23'd0)
    else $error("overflow with fraction");
`endif
endmodule
